@@ rtl/core/dead_reckoning_odometry_macros.svh @@
// assertion macros for the odometry core
`ifndef DEAD_RECKONING_ODOMETRY_MACROS_SVH
`define DEAD_RECKONING_ODOMETRY_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DRO_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define DRO_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DRO_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define DRO_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ rtl/core/dro_pkg.sv @@
// ----------------------------------------------------------------------------
// dro_pkg
// types, codes and tables for the dead-reckoning odometry core
// ----------------------------------------------------------------------------
package dro_pkg;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_TURN     = 2'd1,
        ACT_ADVANCE  = 2'd2,
        ACT_ANALYSIS = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CORDIC,
        ST_MUL,
        ST_HEAD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]   action;
        logic         angle_unit;
        logic [31:0]  magnitude;
        logic [31:0]  start_x;
        logic [31:0]  start_y;
    } in_word_t;

    typedef struct packed {
        logic [31:0]  pos_x;
        logic [31:0]  pos_y;
        logic [31:0]  heading;
        logic         saturated;
    } out_word_t;

    // cordic gain compensation, q30
    localparam logic [33:0] GAIN_Q30 = 34'd652032875;
    // round(2^34 / (2*pi))
    localparam logic [63:0] RAD_TO_BAM = 64'd2734261102;
    localparam logic [9:0]  DEG_DIV    = 10'd360;
    localparam logic [8:0]  DEG_HALF   = 9'd180;

    // arctangent table in binary-angle units
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/dead_reckoning_odometry.sv @@
// path: start and analysis words go straight to the finish state; degree turns
// run the divider, radian turns the multiplier, advances CORDIC then multiplier
// throughput: one word at a time, the next word is taken the cycle after the
// result loads; the CORDIC iteration, the bit-serial shift-add multiplier
// (32 steps) and the restoring divider set it
// reset: synchronous active-low aresetn clears position and heading to zero
// ----------------------------------------------------------------------------
// dead_reckoning_odometry
// keeps rover position and heading from start, turn and advance words
// ----------------------------------------------------------------------------
`include "dead_reckoning_odometry_macros.svh"

module dead_reckoning_odometry import dro_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int NUMW  = 64 - FRAC_BITS;
    localparam int CNT_W = $clog2(NUMW + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        act_reg, act_next;
    logic              rad_reg, rad_next;
    logic              neg_reg, neg_next;
    logic              flip_reg, flip_next;
    logic [31:0]       mag_reg, mag_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic [9:0]        rem_reg, rem_next;
    logic [NUMW-1:0]   quo_reg, quo_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] cz_reg, cz_next;
    logic [63:0]       mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic [63:0]       accx_reg, accx_next, accy_reg, accy_next;
    logic signed [31:0] posx_reg, posx_next, posy_reg, posy_next;
    logic [31:0]       head_reg, head_next;
    logic              sat_reg, sat_next;
    logic              mv_reg, mv_next;
    out_word_t         out_reg, out_next;

    logic              out_free;
    logic [31:0]       m_abs;
    logic [9:0]        rem_sh;
    logic signed [32:0] z0;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    logic [63:0]       rnd_rad;
    logic [31:0]       delta;
    logic signed [63:0] rx, ry;
    logic signed [34:0] sumx, sumy;
    logic              clx, cly;
    logic signed [31:0] nx, ny;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign m_data   = out_reg;
    assign m_abs    = s_data.magnitude[31] ? (32'd0 - s_data.magnitude) : s_data.magnitude;
    assign z0       = {head_reg[31], head_reg};
    assign rem_sh   = {rem_reg[8:0], num_reg[NUMW-1]};
    assign xs       = cx_reg >>> cnt_reg;
    assign ys       = cy_reg >>> cnt_reg;
    assign at       = {1'b0, atan_bam(cnt_reg[4:0])};
    assign rnd_rad  = accx_reg + (64'd1 << (FRAC_BITS + 1));

    // position update with rounding and clipping
    assign rx   = $signed(accx_reg) + 64'sd536870912;
    assign ry   = $signed(accy_reg) + 64'sd536870912;
    assign sumx = 35'(posx_reg) + 35'($signed(rx[63:30]));
    assign sumy = 35'(posy_reg) + 35'($signed(ry[63:30]));
    assign clx  = (sumx > 35'sd2147483647) || (sumx < -35'sd2147483648);
    assign cly  = (sumy > 35'sd2147483647) || (sumy < -35'sd2147483648);
    assign nx   = clx ? (sumx[34] ? 32'sh80000000 : 32'sh7fffffff) : sumx[31:0];
    assign ny   = cly ? (sumy[34] ? 32'sh80000000 : 32'sh7fffffff) : sumy[31:0];

    // heading delta from divider or multiplier
    always_comb begin
        logic [31:0] d;
        d = rad_reg ? rnd_rad[FRAC_BITS+33:FRAC_BITS+2] : quo_reg[31:0];
        delta = neg_reg ? (32'd0 - d) : d;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            posx_reg  <= '0;
            posy_reg  <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            head_reg  <= head_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        act_reg  <= act_next;
        rad_reg  <= rad_next;
        neg_reg  <= neg_next;
        flip_reg <= flip_next;
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        mcx_reg  <= mcx_next;
        mcy_reg  <= mcy_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        sat_reg  <= sat_next;
        out_reg  <= out_next;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        rad_next   = rad_reg;
        neg_next   = neg_reg;
        flip_next  = flip_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        mcx_next   = mcx_reg;
        mcy_next   = mcy_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        head_next  = head_reg;
        sat_next   = sat_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next  = s_data.action;
                    rad_next  = s_data.angle_unit;
                    neg_next  = s_data.magnitude[31];
                    mag_next  = m_abs;
                    sat_next  = 1'b0;
                    cnt_next  = '0;
                    accx_next = '0;
                    accy_next = '0;
                    unique case (action_t'(s_data.action))
                        ACT_START: begin
                            posx_next  = s_data.start_x;
                            posy_next  = s_data.start_y;
                            head_next  = '0;
                            state_next = ST_FINISH;
                        end
                        ACT_TURN: begin
                            num_next = (NUMW'(m_abs) << (32 - FRAC_BITS)) + NUMW'(DEG_HALF);
                            rem_next = '0;
                            quo_next = '0;
                            mcx_next = RAD_TO_BAM;
                            state_next = s_data.angle_unit ? ST_MUL : ST_DIV;
                        end
                        ACT_ADVANCE: begin
                            cx_next = GAIN_Q30;
                            cy_next = '0;
                            if (z0 > 33'sd1073741824) begin
                                cz_next   = z0 - 33'sd2147483648;
                                flip_next = 1'b1;
                            end else if (z0 < -33'sd1073741824) begin
                                cz_next   = z0 + 33'sd2147483648;
                                flip_next = 1'b1;
                            end else begin
                                cz_next   = z0;
                                flip_next = 1'b0;
                            end
                            state_next = ST_CORDIC;
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            // restoring division by 360, one quotient bit per cycle
            ST_DIV: begin
                if (rem_sh >= DEG_DIV) begin
                    rem_next = rem_sh - DEG_DIV;
                    quo_next = {quo_reg[NUMW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[NUMW-2:0], 1'b0};
                end
                num_next = num_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUMW - 1)) state_next = ST_HEAD;
            end
            // one cordic micro-rotation per cycle
            ST_CORDIC: begin
                if (!cz_reg[32]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - at;
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + at;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    cnt_next = '0;
                    if (flip_reg) begin
                        mcx_next = 64'(-cx_next);
                        mcy_next = 64'(-cy_next);
                    end else begin
                        mcx_next = 64'(cx_next);
                        mcy_next = 64'(cy_next);
                    end
                    state_next = ST_MUL;
                end
            end
            // shift-add multiply, one magnitude bit per cycle
            ST_MUL: begin
                if (mag_reg[0]) begin
                    if (neg_reg && act_reg == ACT_ADVANCE) begin
                        accx_next = accx_reg - mcx_reg;
                        accy_next = accy_reg - mcy_reg;
                    end else begin
                        accx_next = accx_reg + mcx_reg;
                        accy_next = accy_reg + mcy_reg;
                    end
                end
                mag_next = mag_reg >> 1;
                mcx_next = mcx_reg << 1;
                mcy_next = mcy_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(31))
                    state_next = (act_reg == ACT_ADVANCE) ? ST_FINISH : ST_HEAD;
            end
            ST_HEAD: begin
                head_next  = head_reg + delta;
                state_next = ST_FINISH;
            end
            // apply advance and load the output word
            ST_FINISH: begin
                if (act_reg == ACT_ADVANCE) begin
                    posx_next = nx;
                    posy_next = ny;
                    sat_next  = clx || cly;
                    act_next  = ACT_ANALYSIS;
                end else if (out_free) begin
                    out_next.pos_x     = posx_reg;
                    out_next.pos_y     = posy_reg;
                    out_next.heading   = head_reg;
                    out_next.saturated = sat_reg;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // checks
    `DRO_ASSERT_NEXT(a_one_word, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DRO_ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == ST_FINISH && act_reg != ACT_ADVANCE && out_free, m_valid && s_ready)
    `DRO_ASSERT_IMPLY(a_cordic_cnt, aclk, aresetn, state_reg == ST_CORDIC, cnt_reg < CNT_W'(CORDIC_STEPS))
    `DRO_ASSERT_IMPLY(a_idle_empty, aclk, aresetn, m_valid && !s_ready, state_reg != ST_IDLE)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed words into the odometry core; a local model of heading,
// cordic and saturating position predicts each result word, checked in order
// ----------------------------------------------------------------------------
module tb_top import dro_pkg::*; ();

    localparam int FRAC = 16;
    localparam int STEPS = 24;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    dead_reckoning_odometry #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // rover state as predicted
    logic signed [31:0] rover_x = '0;
    logic signed [31:0] rover_y = '0;
    logic [31:0]        rover_head = '0;
    out_word_t          pending_pos[$];
    int                 err_count = 0;
    int                 hold_off = 0;
    bit                 gap_burst = 1'b1;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] arctan_step(int i);
        logic [31:0] t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    function automatic logic [31:0] turn_amount(logic signed [31:0] m, logic rad);
        longint mag;
        longint unsigned d;
        mag = (m < 0) ? -longint'(m) : longint'(m);
        if (rad)
            d = (longint'(mag) * 64'd2734261102 + (64'd1 << (FRAC + 1))) >> (FRAC + 2);
        else
            d = ((longint'(mag) << (32 - FRAC)) + 180) / 360;
        if (m < 0) d = -d;
        return d[31:0];
    endfunction

    function automatic void heading_trig(logic [31:0] ang, output longint c,
                                         output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = longint'(signed'(ang));
        x = 652032875;
        y = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31; flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31; flip = 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(arctan_step(i));
            end else begin
                x += ys; y -= xs; z += longint'(arctan_step(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [31:0] clip_pos(longint v, ref bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1; return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            hit = 1; return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // advance the rover model by one word
    function automatic out_word_t rover_update(in_word_t w);
        out_word_t r;
        bit hit;
        longint c, s, m;
        hit = 0;
        m = longint'(signed'(w.magnitude));
        case (action_t'(w.action))
            ACT_START: begin
                rover_x = w.start_x; rover_y = w.start_y; rover_head = '0;
            end
            ACT_TURN: rover_head = rover_head + turn_amount(w.magnitude, w.angle_unit);
            ACT_ADVANCE: begin
                heading_trig(rover_head, c, s);
                rover_x = clip_pos(longint'(rover_x) + floor_sh(m * c + (64'sd1 <<< 29), 30),
                                   hit);
                rover_y = clip_pos(longint'(rover_y) + floor_sh(m * s + (64'sd1 <<< 29), 30),
                                   hit);
            end
            default: ;
        endcase
        r.pos_x = rover_x;
        r.pos_y = rover_y;
        r.heading = rover_head;
        r.saturated = hit;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    // offer one word, honoring burst gaps; valid drops only in a gap or a drain
    task automatic send_word(in_word_t w);
        if (gap_burst && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pos.insert(pending_pos.size(), rover_update(w));
        @(negedge aclk);
    endtask

    function automatic in_word_t make_word(action_t a, logic u, logic [31:0] m,
                                           logic [31:0] x, logic [31:0] y);
        in_word_t w;
        w.action = a; w.angle_unit = u; w.magnitude = m; w.start_x = x; w.start_y = y;
        return w;
    endfunction

    function automatic logic [31:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h80000000 | $urandom_range(0, 3);
            2: return 32'h7fffffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h01000000) ^ ($urandom_range(0, 1) ? '1 : '0);
        endcase
    endfunction

    // stop offering and wait for every expected word
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_pos.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_word(make_word(ACT_ANALYSIS, 1'b1, '1, '1, '1));
        send_word(make_word(ACT_START, 1'b0, 32'h12345678, 32'h7fffffff, 32'h80000000));
        send_word(make_word(ACT_ADVANCE, 1'b0, 32'h7fffffff, '0, '0));
        send_word(make_word(ACT_TURN, 1'b0, 32'd180 << 16, '0, '0));
        send_word(make_word(ACT_ADVANCE, 1'b0, 32'h7fffffff, '0, '0));
        send_word(make_word(ACT_TURN, 1'b0, 32'h80000000, '0, '0));
        send_word(make_word(ACT_TURN, 1'b1, 32'h7fffffff, '0, '0));
        send_word(make_word(ACT_TURN, 1'b1, 32'h80000000, '0, '0));
        send_word(make_word(ACT_START, 1'b1, '1, '0, '0));
        send_word(make_word(ACT_TURN, 1'b0, 32'd90 << 16, '0, '0));
        send_word(make_word(ACT_ADVANCE, 1'b0, 32'h80000000, '0, '0));
        send_word(make_word(ACT_TURN, 1'b0, -(32'd135 << 16), '0, '0));
        send_word(make_word(ACT_ADVANCE, 1'b0, 32'h00010000, '0, '0));
        send_word(make_word(ACT_START, 1'b0, '0, 32'h80000000, 32'h7fffffff));
        send_word(make_word(ACT_ADVANCE, 1'b0, 32'h80000000, '0, '0));
        send_word(make_word(ACT_ANALYSIS, 1'b0, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_random(int count);
        action_t a;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: a = ACT_START;
                1: a = ACT_ANALYSIS;
                2, 3, 4, 5: a = ACT_TURN;
                default: a = ACT_ADVANCE;
            endcase
            send_word(make_word(a, 1'(($urandom)), rand_mag(), $urandom, $urandom));
        end
    endtask

    // long receiver hold-off while words keep being offered without gaps
    task automatic test_backpressure();
        hold_off = 400;
        gap_burst = 1'b0;
        test_random(20);
        gap_burst = 1'b1;
        wait_drain();
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result word checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pos.size() == 0) begin
                report_mismatch("unexpected word", m_data.pos_x, '0);
            end else begin
                want = pending_pos.pop_front();
                if (m_data.pos_x !== want.pos_x) report_mismatch("pos_x", m_data.pos_x, want.pos_x);
                if (m_data.pos_y !== want.pos_y) report_mismatch("pos_y", m_data.pos_y, want.pos_y);
                if (m_data.heading !== want.heading)
                    report_mismatch("heading", m_data.heading, want.heading);
                if (m_data.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(m_data.saturated), 32'(want.saturated));
            end
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random(750);
        wait_drain();
        test_random(760);
        wait_drain();
        repeat (100) @(negedge aclk);
        if (err_count == 0 && pending_pos.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/dro_pkg.sv
rtl/core/dead_reckoning_odometry.sv
test/tb_top.sv
